FILE: rtl/sha1_pkg.sv
// shared types and constants for the sha-1 hash engine
package sha1_pkg;

  localparam logic [31:0] H0_INIT = 32'h67452301;
  localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
  localparam logic [31:0] H2_INIT = 32'h98BADCFE;
  localparam logic [31:0] H3_INIT = 32'h10325476;
  localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;
  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam int unsigned QUEUE_DEPTH = 2;

  // classified request between front and back
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       is_last;
  } sha1_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN,
    ST_ROUND,
    ST_FINAL,
    ST_OUT
  } sha1_state_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned s);
    rotl = (v << s) | (v >> (32 - s));
  endfunction

endpackage

FILE: rtl/sha1_front.sv
// front end: accepts requests, drops empty non-last items, queues the rest
module sha1_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  logic [7:0]          in_data_byte,
  input  logic                in_no_byte,
  input  logic                in_is_last,
  output logic                req_valid,
  output sha1_pkg::sha1_req_t req,
  input  logic                req_take
);

  sha1_pkg::sha1_req_t q_r [sha1_pkg::QUEUE_DEPTH];
  logic        rd_ptr_r, rd_ptr_nxt;
  logic        wr_ptr_r, wr_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        acc, keep;

  assign in_full   = (cnt_r == 2'(sha1_pkg::QUEUE_DEPTH));
  assign acc       = in_push && !in_full;
  assign keep      = acc && (!in_no_byte || in_is_last);
  assign req_valid = (cnt_r != 2'd0);
  assign req       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ keep;
    rd_ptr_nxt = rd_ptr_r ^ (req_take && req_valid);
    cnt_nxt    = cnt_r + {1'b0, keep} - {1'b0, req_take && req_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (keep) begin
      q_r[wr_ptr_r].data_byte <= in_data_byte;
      q_r[wr_ptr_r].has_byte  <= !in_no_byte;
      q_r[wr_ptr_r].is_last   <= in_is_last;
    end
  end

endmodule

FILE: rtl/sha1_core.sv
// back end: block packing, padding, 80-round compression and digest output
module sha1_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                req_valid,
  input  sha1_pkg::sha1_req_t req,
  output logic                req_take,
  output logic                out_empty,
  input  logic                out_pop,
  output logic [31:0]         out_digest_word,
  output logic [2:0]          out_word_index,
  output logic                out_last_word
);

  sha1_pkg::sha1_state_t state_r, state_nxt;

  logic [31:0] w_r [16];
  logic [31:0] h_r [5];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [5:0]  pos_r;
  logic [63:0] len_r;
  logic [6:0]  rnd_r;
  logic [2:0]  oidx_r;
  logic        after_len_r;   // this compression ends the message
  logic        len_pending_r; // length still needs its own block

  logic        is_idle, is_pad, is_len, is_round, is_final, is_out;
  logic [31:0] f, k, t, wnew, wcur;
  logic [7:0]  put_val;
  logic        put_en;
  logic [3:0]  widx;
  logic [4:0]  sh;
  logic        pop_ok;

  assign pop_ok = out_pop && is_out;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sha1_pkg::ST_IDLE: begin
        if (req_valid) begin
          if (req.has_byte && pos_r == 6'd63) state_nxt = sha1_pkg::ST_ROUND;
          else if (req.is_last) state_nxt = sha1_pkg::ST_PAD;
        end
      end
      sha1_pkg::ST_PAD: begin
        if (pos_r == 6'd63) state_nxt = sha1_pkg::ST_ROUND;
        else if (pos_r == 6'd55) state_nxt = sha1_pkg::ST_LEN;
      end
      sha1_pkg::ST_LEN:   state_nxt = sha1_pkg::ST_ROUND;
      sha1_pkg::ST_ROUND: if (rnd_r == 7'd79) state_nxt = sha1_pkg::ST_FINAL;
      sha1_pkg::ST_FINAL: begin
        if (after_len_r) state_nxt = sha1_pkg::ST_OUT;
        else if (len_pending_r) state_nxt = sha1_pkg::ST_PAD;
        else state_nxt = sha1_pkg::ST_IDLE;
      end
      sha1_pkg::ST_OUT: if (pop_ok && oidx_r == 3'd4) state_nxt = sha1_pkg::ST_IDLE;
      default: state_nxt = sha1_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    is_idle  = (state_r == sha1_pkg::ST_IDLE);
    is_pad   = (state_r == sha1_pkg::ST_PAD);
    is_len   = (state_r == sha1_pkg::ST_LEN);
    is_round = (state_r == sha1_pkg::ST_ROUND);
    is_final = (state_r == sha1_pkg::ST_FINAL);
    is_out   = (state_r == sha1_pkg::ST_OUT);
    req_take = is_idle && req_valid;
    out_empty = !is_out;
    put_en   = (req_take && req.has_byte) || is_pad;
    put_val  = req.data_byte;
  end

  // pad byte: 0x80 for the first pad position of a message, zero after
  logic pad_first_r;
  logic [7:0] byte_in;
  assign byte_in = is_pad ? (pad_first_r ? sha1_pkg::PAD_BYTE : 8'h00) : put_val;
  assign widx    = pos_r[5:2];
  assign sh      = {~pos_r[1:0], 3'b000};

  assign wcur = w_r[0];
  assign wnew = sha1_pkg::rotl(w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0], 1);

  always_comb begin
    if (rnd_r < 7'd20) begin
      f = (b_r & c_r) | (~b_r & d_r);
      k = sha1_pkg::K0;
    end else if (rnd_r < 7'd40) begin
      f = b_r ^ c_r ^ d_r;
      k = sha1_pkg::K1;
    end else if (rnd_r < 7'd60) begin
      f = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      k = sha1_pkg::K2;
    end else begin
      f = b_r ^ c_r ^ d_r;
      k = sha1_pkg::K3;
    end
    t = sha1_pkg::rotl(a_r, 5) + f + e_r + k + wcur;
  end

  always_comb begin
    out_digest_word = h_r[oidx_r];
    out_word_index  = oidx_r;
    out_last_word   = (oidx_r == 3'd4);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= sha1_pkg::ST_IDLE;
      pos_r         <= 6'd0;
      len_r         <= 64'd0;
      rnd_r         <= 7'd0;
      oidx_r        <= 3'd0;
      after_len_r   <= 1'b0;
      len_pending_r <= 1'b0;
      pad_first_r   <= 1'b0;
      h_r[0] <= sha1_pkg::H0_INIT;
      h_r[1] <= sha1_pkg::H1_INIT;
      h_r[2] <= sha1_pkg::H2_INIT;
      h_r[3] <= sha1_pkg::H3_INIT;
      h_r[4] <= sha1_pkg::H4_INIT;
    end else begin
      state_r <= state_nxt;
      if (put_en) begin
        pos_r <= pos_r + 6'd1;
        if (pos_r[1:0] == 2'd0) w_r[widx] <= {24'd0, byte_in} << sh;
        else w_r[widx] <= w_r[widx] | ({24'd0, byte_in} << sh);
      end
      if (req_take && req.has_byte) len_r <= len_r + 64'd8;
      if (req_take && req.is_last) begin
        pad_first_r   <= 1'b1;
        len_pending_r <= 1'b1;
      end
      if (is_pad) pad_first_r <= 1'b0;
      if (is_len) begin
        w_r[14]       <= len_r[63:32];
        w_r[15]       <= len_r[31:0];
        pos_r         <= 6'd0;
        after_len_r   <= 1'b1;
        len_pending_r <= 1'b0;
      end
      if (state_nxt == sha1_pkg::ST_ROUND && !is_round) begin
        a_r <= h_r[0]; b_r <= h_r[1]; c_r <= h_r[2]; d_r <= h_r[3]; e_r <= h_r[4];
        rnd_r <= 7'd0;
      end
      if (is_round) begin
        a_r <= t; b_r <= a_r; c_r <= sha1_pkg::rotl(b_r, 30); d_r <= c_r; e_r <= d_r;
        for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
        w_r[15] <= wnew;
        rnd_r <= rnd_r + 7'd1;
      end
      if (is_final) begin
        h_r[0] <= h_r[0] + a_r; h_r[1] <= h_r[1] + b_r; h_r[2] <= h_r[2] + c_r;
        h_r[3] <= h_r[3] + d_r; h_r[4] <= h_r[4] + e_r;
        oidx_r <= 3'd0;
      end
      if (pop_ok) begin
        oidx_r <= (oidx_r == 3'd4) ? 3'd0 : oidx_r + 3'd1;
        if (oidx_r == 3'd4) begin
          h_r[0] <= sha1_pkg::H0_INIT; h_r[1] <= sha1_pkg::H1_INIT;
          h_r[2] <= sha1_pkg::H2_INIT; h_r[3] <= sha1_pkg::H3_INIT;
          h_r[4] <= sha1_pkg::H4_INIT;
          len_r <= 64'd0; pos_r <= 6'd0; after_len_r <= 1'b0;
        end
      end
    end
  end

endmodule

FILE: rtl/sha1_hash_engine.sv
// top level of the streaming sha-1 hash engine
// Streaming SHA-1: one message byte per request (or none, with no_byte),
// is_last closes the message, pads it and yields five digest words h0..h4,
// h4 marked last_word. A front queue of two requests parts the input from
// the compression unit. A byte that does not fill a block is packed into
// its block word when the core is idle, and such bytes can follow one per
// cycle while it stays idle; the 64th byte of a block starts a compression
// (load, one sha-1 round per cycle, chaining add). A last request adds
// padding and one or two compressions, then five results that wait on pop.
module sha1_hash_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_no_byte,
  input  logic        in_is_last,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  // request path between front queue and compression core
  logic                req_valid;
  logic                req_take;
  sha1_pkg::sha1_req_t req;

  sha1_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_data_byte, .in_no_byte, .in_is_last,
    .req_valid, .req, .req_take
  );

  sha1_core u_core (
    .clk, .rst_n, .req_valid, .req, .req_take, .out_empty, .out_pop,
    .out_digest_word, .out_word_index, .out_last_word
  );

  // last_word comes only on index four
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_last_word == (out_word_index == 3'd4)))
    else $error("last_word mismatch");

  // core never takes a request while results wait
  a_no_take_out: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> !req_take)
    else $error("request taken during output");

  // a popped non-last word advances the index
  a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_pop && !out_last_word) |=>
      (!out_empty && out_word_index == $past(out_word_index) + 3'd1))
    else $error("word index did not advance");

endmodule
